@@ src/pwmsch_pkg.sv @@
// shared types and constants for the multichannel pwm event scheduler
// no dependencies
package pwmsch_pkg;

    localparam logic [31:0] NO_EVENT = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        CMD_EXPIRY  = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_ADJUST  = 2'd2,
        CMD_DISABLE = 2'd3
    } cmd_t;

    typedef enum logic {
        KIND_PIN  = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_SCAN,
        ST_EXP_UPD,
        ST_EXP_DONE,
        ST_ENA_FIND,
        ST_ENA_SCAN,
        ST_ENA_CMP,
        ST_ENA_SET,
        ST_REFRESH,
        ST_FIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  channel;
        logic [7:0]  pin_number;
        logic [23:0] on_time;
        logic [23:0] off_time;
        logic [15:0] counter_now;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_pin;
        logic        level;
        logic [3:0]  slot;
        logic        ok;
        logic        reload_valid;
        logic [15:0] reload_value;
        logic [15:0] counter_load;
        logic        last;
    } out_word_t;

endpackage

@@ src/multichannel_pwm_event_scheduler.sv @@
// pwm slot scheduler sharing one reload timer: sequencer, slot state, phase ram
// expiry walks the active range; enable finds a free slot, walks the range for an
// equal-period slot to align to, rescans all slots and responds; disable rescans and
// responds; adjust responds directly. one word at a time, ready only while idle.
// throughput is set by the single walk counter and the phase ram's single read port
// reset: asynchronous active low, clears enables, time base (delta one), active range
module multichannel_pwm_event_scheduler
    import pwmsch_pkg::*;
#(
    parameter int SLOTS       = 16,
    parameter int COUNTER_MAX = 65535
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = SW + 1;
    localparam int RD = 2 * SLOTS;
    localparam int AW = $clog2(RD);

    // per-slot state, read through the walk index
    logic [31:0] net_arr [SLOTS];
    logic [7:0]  pin_arr [SLOTS];
    logic [SLOTS-1:0] low_arr, ab_arr, pend_arr, en_reg;

    // control and time base
    state_t      state_reg, state_next;
    logic [31:0] base_time_reg, base_time_next;
    logic [15:0] base_delta_reg, base_delta_next;
    logic [SW-1:0] first_reg, first_next;
    logic [CW-1:0] end_reg, end_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    // working registers of the current word
    cmd_t        cmd_reg;
    logic [7:0]  pin_reg;
    logic [23:0] on_reg, off_reg;
    logic [24:0] cycle_reg;
    logic [15:0] cnt_reg;
    logic [CW-1:0] i_reg, i_next;
    logic [SW-1:0] s_reg, s_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] d_reg, d_next;
    logic        ok_reg, ok_next;
    logic        run_reg, run_next;
    logic        any_reg, any_next;
    logic [SW-1:0] fa_reg, fa_next;
    logic [CW-1:0] le_reg, le_next;

    // array write strobes
    logic        net_we;
    logic [SW-1:0] net_idx;
    logic [31:0] net_wd;
    logic        setup_we;
    logic        flag_we;
    logic        flag_low, flag_ab, flag_pend;
    logic        pend_set;
    logic [SW-1:0] pend_idx;
    logic        en_set, en_clr;
    logic [SW-1:0] en_idx;

    // phase ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [47:0]   ram_wdata, ram_rdata;

    logic [SW-1:0] iidx;
    logic          accept, can_push;
    logic [31:0]   d_now, d_add, ncl;
    logic [23:0]   ph_time;
    logic [15:0]   tick, cd;
    logic          due, nlow, nab, ch_bad, rv;

    pwmsch_ram #(.WIDTH(48), .DEPTH(RD)) u_phase_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign iidx      = i_reg[SW-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign can_push  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign ch_bad    = (32'(in_word.channel) >= SLOTS);

    always_comb
    begin
        state_next      = state_reg;
        base_time_next  = base_time_reg;
        base_delta_next = base_delta_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        i_next          = i_reg;
        s_next          = s_reg;
        now_next        = now_reg;
        min_next        = min_reg;
        d_next          = d_reg;
        ok_next         = ok_reg;
        run_next        = run_reg;
        any_next        = any_reg;
        fa_next         = fa_reg;
        le_next         = le_reg;
        net_we    = 1'b0;
        net_idx   = iidx;
        net_wd    = '0;
        setup_we  = 1'b0;
        flag_we   = 1'b0;
        flag_low  = 1'b0;
        flag_ab   = 1'b0;
        flag_pend = 1'b0;
        pend_set  = 1'b0;
        pend_idx  = SW'(in_word.channel);
        en_set    = 1'b0;
        en_clr    = 1'b0;
        en_idx    = SW'(in_word.channel);
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {on_reg, off_reg};
        ram_raddr = AW'({iidx, ab_arr[iidx]});
        d_now   = net_arr[iidx] - now_reg;
        due     = (d_now == 32'd0) || d_now[31];
        nlow    = !low_arr[iidx];
        nab     = (!nlow && pend_arr[iidx]) ? !ab_arr[iidx] : ab_arr[iidx];
        ph_time = low_arr[iidx] ? ram_rdata[23:0] : ram_rdata[47:24];
        d_add   = d_reg + 32'(ph_time);
        ncl     = (min_reg > 32'(COUNTER_MAX)) ? 32'(COUNTER_MAX) : min_reg;
        tick    = cnt_reg + 16'd1;
        cd      = (cnt_reg == 16'd0) ? 16'd1 : cnt_reg;
        rv      = any_reg ? !run_reg : 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(in_word.cmd))
                        CMD_EXPIRY:
                        begin
                            now_next       = base_time_reg + 32'(base_delta_reg);
                            base_time_next = now_next;
                            min_next       = NO_EVENT;
                            i_next         = CW'(first_reg);
                            state_next     = ST_EXP_SCAN;
                        end
                        CMD_ENABLE:
                        begin
                            i_next     = '0;
                            state_next = ST_ENA_FIND;
                        end
                        CMD_ADJUST:
                        begin
                            ok_next    = !ch_bad;
                            state_next = ST_RESP;
                            if (!ch_bad)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'({SW'(in_word.channel),
                                                 !ab_arr[SW'(in_word.channel)]});
                                ram_wdata = {in_word.on_time, in_word.off_time};
                                pend_set  = 1'b1;
                            end
                        end
                        CMD_DISABLE:
                        begin
                            if (ch_bad)
                            begin
                                ok_next    = 1'b0;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                en_clr     = 1'b1;
                                run_next   = (end_reg != '0);
                                i_next     = '0;
                                any_next   = 1'b0;
                                state_next = ST_REFRESH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // walk the active range, toggling due slots
            ST_EXP_SCAN:
            begin
                if (i_reg >= end_reg || i_reg >= CW'(SLOTS))
                begin
                    state_next = ST_EXP_DONE;
                end
                else if (!en_reg[iidx])
                begin
                    i_next = i_reg + 1'b1;
                end
                else if (!due)
                begin
                    if (d_now < min_reg)
                    begin
                        min_next = d_now;
                    end
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    flag_we    = 1'b1;
                    flag_low   = nlow;
                    flag_ab    = nab;
                    flag_pend  = nlow ? pend_arr[iidx] : 1'b0;
                    ram_raddr  = AW'({iidx, nab});
                    d_next     = d_now;
                    state_next = ST_EXP_UPD;
                end
            end

            // phase time is in, move the edge and send the pin write
            ST_EXP_UPD:
            begin
                if (can_push)
                begin
                    net_we = 1'b1;
                    net_wd = net_arr[iidx] + 32'(ph_time);
                    if (!d_add[31] && d_add < min_reg)
                    begin
                        min_next = d_add;
                    end
                    else if (d_add[31])
                    begin
                        min_next = 32'd0;
                    end
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.kind        = KIND_PIN;
                    out_next.out_pin     = pin_arr[iidx];
                    out_next.level       = !low_arr[iidx];
                    out_next.slot        = 4'(iidx);
                    out_next.ok          = 1'b1;
                    i_next               = i_reg + 1'b1;
                    state_next           = ST_EXP_SCAN;
                end
            end

            ST_EXP_DONE:
            begin
                if (can_push)
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.kind         = KIND_DONE;
                    out_next.ok           = 1'b1;
                    out_next.reload_valid = 1'b1;
                    out_next.counter_load = tick;
                    out_next.last         = 1'b1;
                    if (32'(tick) > ncl)
                    begin
                        out_next.reload_value = tick;
                        base_delta_next       = tick;
                    end
                    else
                    begin
                        out_next.reload_value = ncl[15:0];
                        base_delta_next       = ncl[15:0];
                    end
                    state_next = ST_IDLE;
                end
            end

            // first free slot
            ST_ENA_FIND:
            begin
                if (i_reg >= CW'(SLOTS))
                begin
                    ok_next    = 1'b0;
                    state_next = ST_RESP;
                end
                else if (!en_reg[iidx])
                begin
                    s_next     = iidx;
                    setup_we   = 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = AW'({iidx, 1'b0});
                    i_next     = CW'(first_reg);
                    state_next = ST_ENA_SCAN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            // look for an enabled slot of equal period
            ST_ENA_SCAN:
            begin
                if (i_reg >= end_reg || i_reg >= CW'(SLOTS))
                begin
                    net_we          = 1'b1;
                    net_idx         = s_reg;
                    net_wd          = base_time_reg + 32'(cd);
                    base_delta_next = cd;
                    state_next      = ST_ENA_SET;
                end
                else if (en_reg[iidx])
                begin
                    state_next = ST_ENA_CMP;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            ST_ENA_CMP:
            begin
                if (25'(ram_rdata[47:24]) + 25'(ram_rdata[23:0]) == cycle_reg)
                begin
                    net_we     = 1'b1;
                    net_idx    = s_reg;
                    net_wd     = net_arr[iidx] +
                                 (low_arr[iidx] ? 32'd0 : 32'(ram_rdata[23:0]));
                    state_next = ST_ENA_SET;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ENA_SCAN;
                end
            end

            ST_ENA_SET:
            begin
                en_set     = 1'b1;
                en_idx     = s_reg;
                run_next   = 1'b0;
                i_next     = '0;
                any_next   = 1'b0;
                state_next = ST_REFRESH;
            end

            // rebuild the active range
            ST_REFRESH:
            begin
                if (i_reg >= CW'(SLOTS))
                begin
                    first_next = any_reg ? fa_reg : '0;
                    end_next   = any_reg ? le_reg : '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    if (en_reg[iidx])
                    begin
                        if (!any_reg)
                        begin
                            fa_next = iidx;
                        end
                        any_next = 1'b1;
                        le_next  = i_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end

            ST_FIN:
            begin
                if (can_push)
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.kind         = KIND_DONE;
                    out_next.ok           = 1'b1;
                    out_next.slot         = (cmd_reg == CMD_ENABLE) ? 4'(s_reg) : 4'd0;
                    out_next.reload_valid = rv;
                    out_next.reload_value = (rv && any_reg) ? base_delta_reg : 16'd0;
                    out_next.counter_load = rv ? cnt_reg : 16'd0;
                    out_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_RESP:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = KIND_DONE;
                    out_next.ok    = ok_reg;
                    out_next.last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_time_reg  <= '0;
            base_delta_reg <= 16'd1;
            first_reg      <= '0;
            end_reg        <= '0;
            out_valid_reg  <= 1'b0;
            en_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_time_reg  <= base_time_next;
            base_delta_reg <= base_delta_next;
            first_reg      <= first_next;
            end_reg        <= end_next;
            out_valid_reg  <= out_valid_next;
            if (en_set)
            begin
                en_reg[en_idx] <= 1'b1;
            end
            if (en_clr)
            begin
                en_reg[en_idx] <= 1'b0;
            end
        end
    end

    // payload and slot storage
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        i_reg   <= i_next;
        s_reg   <= s_next;
        now_reg <= now_next;
        min_reg <= min_next;
        d_reg   <= d_next;
        ok_reg  <= ok_next;
        run_reg <= run_next;
        any_reg <= any_next;
        fa_reg  <= fa_next;
        le_reg  <= le_next;
        if (accept)
        begin
            cmd_reg   <= cmd_t'(in_word.cmd);
            pin_reg   <= in_word.pin_number;
            on_reg    <= in_word.on_time;
            off_reg   <= in_word.off_time;
            cycle_reg <= 25'(in_word.on_time) + 25'(in_word.off_time);
            cnt_reg   <= in_word.counter_now;
        end
        if (net_we)
        begin
            net_arr[net_idx] <= net_wd;
        end
        if (setup_we)
        begin
            pin_arr[iidx]  <= pin_reg;
            low_arr[iidx]  <= 1'b1;
            ab_arr[iidx]   <= 1'b0;
            pend_arr[iidx] <= 1'b0;
        end
        if (flag_we)
        begin
            low_arr[iidx]  <= flag_low;
            ab_arr[iidx]   <= flag_ab;
            pend_arr[iidx] <= flag_pend;
        end
        if (pend_set)
        begin
            pend_arr[pend_idx] <= 1'b1;
        end
    end
endmodule

@@ src/pwmsch_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module pwmsch_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ tb/multichannel_pwm_event_scheduler_test.sv @@
// self-checking testbench for the multichannel pwm event scheduler
// depends on pwmsch_pkg and multichannel_pwm_event_scheduler
module multichannel_pwm_event_scheduler_test;
    import pwmsch_pkg::*;

    localparam int NSLOT      = 16;
    localparam int RAND_WORDS = 405;
    localparam int IDLE_PCT   = 23;
    localparam int HOLD_AT    = 180;   // word index where the long receiver hold-off starts
    localparam int HOLD_LEN   = 400;
    localparam int CALM_FROM  = 280;   // stretch with no idling on either side
    localparam int CALM_TO    = 340;
    localparam int STALL_MAX  = 5000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYC  = 80;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    multichannel_pwm_event_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // scheduler shadow state
    logic [31:0] edge_due [NSLOT];
    logic [7:0]  slot_pin_of [NSLOT];
    logic [23:0] phase_len [NSLOT][2][2];   // [slot][buffer][0 on, 1 off]
    bit          low_phase [NSLOT];
    bit          buf_sel [NSLOT];
    bit          swap_pending [NSLOT];
    bit          enabled [NSLOT];
    bit          ever_enabled [NSLOT];
    logic [31:0] time_base;
    logic [15:0] delta_base;
    int          range_first;
    int          range_end;

    out_word_t   expected_words[$];
    int          errors;
    int          idle_cycles;
    int          hold_left;
    bit          calm;
    int          n_pin_writes;
    int          n_done;
    int          n_full;
    int          n_words;

    // directed table
    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t e;
    } row_t;
    row_t rows[$];

    function automatic out_word_t mk_word(kind_t k, logic [7:0] pin, logic lvl,
                                          logic [3:0] sl, logic ok, logic rv,
                                          logic [15:0] rval, logic [15:0] cload);
        out_word_t o;
        o.kind         = k;
        o.out_pin      = pin;
        o.level        = lvl;
        o.slot         = sl;
        o.ok           = ok;
        o.reload_valid = rv;
        o.reload_value = rval;
        o.counter_load = cload;
        o.last         = (k == KIND_DONE);
        return o;
    endfunction

    function automatic in_word_t mk_in(cmd_t c, logic [3:0] ch, logic [7:0] pin,
                                       logic [23:0] on_t, logic [23:0] off_t,
                                       logic [15:0] cnt);
        in_word_t w;
        w.cmd         = c;
        w.channel     = ch;
        w.pin_number  = pin;
        w.on_time     = on_t;
        w.off_time    = off_t;
        w.counter_now = cnt;
        return w;
    endfunction

    // recompute the active slot range; returns 1 when the reload must be rewritten
    function automatic bit refresh_range(output logic [15:0] reload);
        bit any;
        bit running;
        any     = 0;
        running = (range_end != 0);
        reload  = 16'd0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (enabled[i])
            begin
                if (!any)
                    range_first = i;
                any       = 1;
                range_end = i + 1;
            end
        end
        if (any)
        begin
            if (!running)
            begin
                reload = delta_base;
                return 1;
            end
            return 0;
        end
        range_first = 0;
        range_end   = 0;
        return 1;
    endfunction

    // advance the shadow scheduler by one word and queue the words it produces
    function automatic void schedule_word(in_word_t w);
        logic [31:0] nearest;
        logic [31:0] now;
        logic [31:0] d;
        logic [31:0] tick;
        logic [31:0] period;
        logic [15:0] cd;
        logic [15:0] reload;
        bit          b;
        bit          aligned;
        int          s;
        case (cmd_t'(w.cmd))
            CMD_EXPIRY:
            begin
                nearest   = NO_EVENT;
                now       = time_base + 32'(delta_base);
                time_base = now;
                for (int i = range_first; i < range_end; i++)
                begin
                    if (!enabled[i])
                        continue;
                    d = edge_due[i] - now;
                    if (d == 0 || d[31])
                    begin
                        low_phase[i] = !low_phase[i];
                        if (!low_phase[i] && swap_pending[i])
                        begin
                            buf_sel[i]      = !buf_sel[i];
                            swap_pending[i] = 0;
                        end
                        expected_words.push_back(mk_word(KIND_PIN, slot_pin_of[i],
                            !low_phase[i], 4'(i), 1'b1, 1'b0, 16'd0, 16'd0));
                        n_pin_writes++;
                        d = d + 32'(phase_len[i][buf_sel[i]][low_phase[i]]);
                        edge_due[i] = now + d;
                        if (d[31])
                            d = 0;   // late edge counts as due now
                    end
                    if (d < nearest)
                        nearest = d;
                end
                if (nearest > 32'h0000_ffff)
                    nearest = 32'h0000_ffff;
                tick = 32'(16'(w.counter_now + 16'd1));
                if (tick > nearest)
                    nearest = tick;
                delta_base = nearest[15:0];
                expected_words.push_back(mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1,
                    1'b1, nearest[15:0], tick[15:0]));
            end
            CMD_ENABLE:
            begin
                s = 0;
                while (s < NSLOT && enabled[s])
                    s++;
                if (s >= NSLOT)
                begin
                    expected_words.push_back(mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b0,
                        1'b0, 16'd0, 16'd0));
                    n_full++;
                    return;
                end
                slot_pin_of[s]     = w.pin_number;
                phase_len[s][0][0] = w.on_time;
                phase_len[s][0][1] = w.off_time;
                buf_sel[s]         = 0;
                low_phase[s]       = 1;
                swap_pending[s]    = 0;
                ever_enabled[s]    = 1;
                period  = 32'(w.on_time) + 32'(w.off_time);
                aligned = 0;
                // phase-align to the first enabled slot with the same period
                for (int i = range_first; i < range_end; i++)
                begin
                    b = buf_sel[i];
                    if (enabled[i] &&
                        32'(phase_len[i][b][0]) + 32'(phase_len[i][b][1]) == period)
                    begin
                        edge_due[s] = edge_due[i] +
                            (low_phase[i] ? 32'd0 : 32'(phase_len[i][b][1]));
                        aligned = 1;
                        break;
                    end
                end
                if (!aligned)
                begin
                    cd          = (w.counter_now == 0) ? 16'd1 : w.counter_now;
                    edge_due[s] = time_base + 32'(cd);
                    delta_base  = cd;
                end
                enabled[s] = 1;
                range_end  = 0;   // forces a timer restart
                void'(refresh_range(reload));
                expected_words.push_back(mk_word(KIND_DONE, 8'd0, 1'b0, 4'(s), 1'b1,
                    1'b1, reload, w.counter_now));
            end
            CMD_ADJUST:
            begin
                b = !buf_sel[w.channel];
                phase_len[w.channel][b][0] = w.on_time;
                phase_len[w.channel][b][1] = w.off_time;
                swap_pending[w.channel]    = 1;
                expected_words.push_back(mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1,
                    1'b0, 16'd0, 16'd0));
            end
            default:
            begin
                enabled[w.channel] = 0;
                if (refresh_range(reload))
                    expected_words.push_back(mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1,
                        1'b1, reload, w.counter_now));
                else
                    expected_words.push_back(mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1,
                        1'b0, 16'd0, 16'd0));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch(name, got, want);
    endtask

    // directed rows: extremes, alignment, adjust, late edges and a full table
    task automatic add_row(in_word_t w, bit typed, out_word_t e);
        row_t r;
        r.w     = w;
        r.typed = typed;
        r.e     = e;
        rows.push_back(r);
    endtask

    task automatic build_rows();
        out_word_t none;
        none = '0;
        // expiry straight after reset, nothing active, counter wraps to zero
        add_row(mk_in(CMD_EXPIRY, 4'hf, 8'h00, 24'h0, 24'h0, 16'hffff), 1,
                mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1, 1'b1, 16'hffff, 16'h0000));
        // disable of a free slot with nothing enabled stops the timer
        add_row(mk_in(CMD_DISABLE, 4'hf, 8'h00, 24'h0, 24'h0, 16'h1234), 1,
                mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1, 1'b1, 16'h0000, 16'h1234));
        // zero counter on enable is raised to one
        add_row(mk_in(CMD_ENABLE, 4'h0, 8'hff, 24'hffffff, 24'hffffff, 16'h0000), 1,
                mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1, 1'b1, 16'h0001, 16'h0000));
        add_row(mk_in(CMD_ENABLE, 4'h0, 8'h00, 24'h0, 24'h0, 16'hffff), 1,
                mk_word(KIND_DONE, 8'd0, 1'b0, 4'd1, 1'b1, 1'b1, 16'hffff, 16'hffff));
        add_row(mk_in(CMD_ENABLE, 4'h0, 8'h5a, 24'd100, 24'd200, 16'd50), 0, none);
        // same period as the slot before: phase-aligned
        add_row(mk_in(CMD_ENABLE, 4'h0, 8'ha5, 24'd200, 24'd100, 16'd70), 0, none);
        add_row(mk_in(CMD_ADJUST, 4'h2, 8'h00, 24'd10, 24'd20, 16'h0), 1,
                mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b1, 1'b0, 16'd0, 16'd0));
        add_row(mk_in(CMD_EXPIRY, 4'h0, 8'h00, 24'h0, 24'h0, 16'h0000), 0, none);
        // large counter pushes edges into the past
        add_row(mk_in(CMD_EXPIRY, 4'h0, 8'h00, 24'h0, 24'h0, 16'hfff0), 0, none);
        add_row(mk_in(CMD_EXPIRY, 4'h0, 8'h00, 24'h0, 24'h0, 16'h8000), 0, none);
        add_row(mk_in(CMD_DISABLE, 4'h1, 8'h00, 24'h0, 24'h0, 16'h0042), 0, none);
        for (int i = 0; i < 13; i++)
            add_row(mk_in(CMD_ENABLE, 4'(i), 8'(8'h10 + i), 24'(150 + i), 24'(150 - i),
                          16'(i * 977)), 0, none);
        // every slot taken
        add_row(mk_in(CMD_ENABLE, 4'h0, 8'h77, 24'd5, 24'd5, 16'h0100), 1,
                mk_word(KIND_DONE, 8'd0, 1'b0, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0));
    endtask

    function automatic logic [23:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 24'($urandom);
        if (r < 10)
            return 24'd0;
        return 24'($urandom_range(1, 4000));
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int       r;
        int       n_on;
        int       ch;
        w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom}));
        n_on = 0;
        for (int i = 0; i < NSLOT; i++)
            n_on += enabled[i];
        r = $urandom_range(99);
        if (r < 48)
            w.cmd = CMD_EXPIRY;
        else if (r < 66)
            w.cmd = (n_on >= 12 && $urandom_range(1)) ? CMD_DISABLE : CMD_ENABLE;
        else if (r < 83)
            w.cmd = CMD_ADJUST;
        else
            w.cmd = CMD_DISABLE;
        if (w.cmd != CMD_EXPIRY && $urandom_range(99) < 85)
        begin
            w.on_time  = pick_len();
            w.off_time = pick_len();
            if ($urandom_range(2) == 0)
            begin
                // shared period so alignment gets exercised
                w.on_time  = 24'($urandom_range(0, 300));
                w.off_time = 24'd300 - w.on_time;
            end
        end
        if (w.cmd == CMD_ADJUST)
        begin
            // only adjust slots whose buffers have been written
            ch = $urandom_range(NSLOT - 1);
            for (int k = 0; k < NSLOT && !ever_enabled[ch]; k++)
                ch = (ch + 1) % NSLOT;
            if (ever_enabled[ch])
                w.channel = 4'(ch);
            else
                w.cmd = CMD_ENABLE;
        end
        if (w.cmd == CMD_DISABLE && n_on > 0 && $urandom_range(3) != 0)
        begin
            ch = $urandom_range(NSLOT - 1);
            while (!enabled[ch])
                ch = (ch + 1) % NSLOT;
            w.channel = 4'(ch);
        end
        return w;
    endfunction

    // offers one word on the input side and waits for its handshake
    task automatic send_word(in_word_t w);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        schedule_word(w);
        n_words++;
        @(negedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset, stimulus and end of run
    initial
    begin
        in_word_t w;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        errors      = 0;
        calm        = 0;
        hold_left   = 0;
        n_words     = 0;
        n_pin_writes = 0;
        n_done      = 0;
        n_full      = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            enabled[i]      = 0;
            ever_enabled[i] = 0;
        end
        time_base   = 32'd0;
        delta_base  = 16'd1;
        range_first = 0;
        range_end   = 0;
        build_rows();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, typed rows replace the predicted word
        foreach (rows[i])
        begin
            send_word(rows[i].w);
            if (rows[i].typed)
            begin
                void'(expected_words.pop_back());
                expected_words.push_back(rows[i].e);
            end
        end

        // random traffic
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n == HOLD_AT)
                hold_left = HOLD_LEN;
            calm = (n >= CALM_FROM && n < CALM_TO);
            w = random_word();
            send_word(w);
        end
        in_valid <= 1'b0;
        calm = 0;

        wait (expected_words.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        $display("%0d words sent (%0d directed), %0d pin writes and %0d completions checked",
                 n_words, rows.size(), n_pin_writes, n_done);
        $display("%0d enables hit a full slot table, receiver held off %0d cycles once",
                 n_full, HOLD_LEN);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, one long hold-off, quiet stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, kind", out_word.kind, 0);
            else
            begin
                e = expected_words.pop_front();
                if (e.kind == KIND_DONE)
                    n_done++;
                check_field("kind", out_word.kind, e.kind);
                check_field("out_pin", out_word.out_pin, e.out_pin);
                check_field("level", out_word.level, e.level);
                check_field("slot", out_word.slot, e.slot);
                check_field("ok", out_word.ok, e.ok);
                check_field("reload_valid", out_word.reload_valid, e.reload_valid);
                check_field("reload_value", out_word.reload_value, e.reload_value);
                check_field("counter_load", out_word.counter_load, e.counter_load);
                check_field("last", out_word.last, e.last);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("timeout: no handshake for %0d cycles, %0d words still expected",
                     STALL_MAX, expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
